### sv/gntm_pkg.sv
`timescale 1ns / 1ps

package gntm_pkg;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } gntm_state_e;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_MATCH = 1'b1;

  typedef struct packed {
    logic load;
    logic start_match;
    logic issue;
    logic result;
  } gntm_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic pipe_busy;
  } gntm_status_t;

endpackage

### sv/gntm_datapath.sv
`timescale 1ns / 1ps

module gntm_datapath #(
  parameter int STORE_DEPTH = 1024,
  parameter int STAMP_BITS  = 48,
  parameter int IDX_W       = $clog2(STORE_DEPTH),
  parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gntm_pkg::gntm_cmd_t         cmd_i,
  output gntm_pkg::gntm_status_t      status_o,
  input  logic [STAMP_BITS-1:0]       stamp_i,
  output logic [IDX_W-1:0]            match_index_o,
  output logic signed [STAMP_BITS:0]  time_offset_o,
  output logic                        no_match_o
);
  import gntm_pkg::*;

  logic [STAMP_BITS-1:0] stamp_mem [STORE_DEPTH];
  logic                  free_mem  [STORE_DEPTH];

  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      addr_q, addr_d;
  logic [STAMP_BITS-1:0] trig_q;

  logic                  rd_en;
  logic                  load_wr;
  logic                  rd_v_q;
  logic [STAMP_BITS-1:0] stamp_rd_q;
  logic                  free_rd_q;
  logic [IDX_W-1:0]      rd_idx_q;

  logic [STAMP_BITS:0]   diff_w, ndiff_w;
  logic [STAMP_BITS-1:0] dist_w;
  logic                  cand_v_q;
  logic [STAMP_BITS-1:0] dist_q;
  logic [STAMP_BITS:0]   diff_q;
  logic [IDX_W-1:0]      cand_idx_q;

  logic                  found_q;
  logic                  better;
  logic [IDX_W-1:0]      best_idx_q;
  logic [STAMP_BITS-1:0] best_dist_q;
  logic [STAMP_BITS:0]   best_diff_q;

  assign load_wr = cmd_i.load && (count_q < CNT_W'(STORE_DEPTH));
  assign rd_en   = cmd_i.issue && !status_o.scan_end;

  assign status_o.scan_end  = (addr_q == count_q);
  assign status_o.pipe_busy = rd_v_q || cand_v_q;

  always_comb begin
    count_d = count_q;
    if (load_wr) begin
      count_d = count_q + CNT_W'(1);
    end
    addr_d = addr_q;
    if (cmd_i.start_match) begin
      addr_d = '0;
    end else if (rd_en) begin
      addr_d = addr_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      addr_q  <= '0;
    end else begin
      count_q <= count_d;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_match) begin
      trig_q <= stamp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      stamp_mem[count_q[IDX_W-1:0]] <= stamp_i;
    end
    if (rd_en) begin
      stamp_rd_q <= stamp_mem[addr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      free_mem[count_q[IDX_W-1:0]] <= 1'b1;
    end else if (cmd_i.result && found_q) begin
      free_mem[best_idx_q] <= 1'b0;
    end
    if (rd_en) begin
      free_rd_q <= free_mem[addr_q[IDX_W-1:0]];
      rd_idx_q  <= addr_q[IDX_W-1:0];
    end
  end

  assign diff_w  = {1'b0, stamp_rd_q} - {1'b0, trig_q};
  assign ndiff_w = {1'b0, trig_q} - {1'b0, stamp_rd_q};
  assign dist_w  = diff_w[STAMP_BITS] ? ndiff_w[STAMP_BITS-1:0] : diff_w[STAMP_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      cand_v_q <= 1'b0;
    end else begin
      rd_v_q   <= rd_en;
      cand_v_q <= rd_v_q && free_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      dist_q     <= dist_w;
      diff_q     <= diff_w;
      cand_idx_q <= rd_idx_q;
    end
  end

  assign better = cand_v_q && (!found_q || (dist_q < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.start_match) begin
      found_q <= 1'b0;
    end else if (better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (better) begin
      best_idx_q  <= cand_idx_q;
      best_dist_q <= dist_q;
      best_diff_q <= diff_q;
    end
  end

  assign match_index_o = found_q ? best_idx_q : '0;
  assign time_offset_o = found_q ? $signed(best_diff_q) : '0;
  assign no_match_o    = !found_q;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STORE_DEPTH))
    else $error("Fill count exceeds the store depth.");

  a_addr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_q <= count_q)
    else $error("Scan address ran past the fill count.");

  a_best_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.result && found_q) |-> ({{(CNT_W-IDX_W){1'b0}}, best_idx_q} < count_q))
    else $error("Chosen entry lies beyond the loaded entries.");
`endif

endmodule

### sv/gntm_ctrl.sv
`timescale 1ns / 1ps

module gntm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   kind_i,
  input  gntm_pkg::gntm_status_t status_i,
  output gntm_pkg::gntm_cmd_t    cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import gntm_pkg::*;

  gntm_state_e state_q, state_d;
  logic        accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (kind_i == KIND_MATCH)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.scan_end) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load        = accept && (kind_i == KIND_LOAD);
  assign cmd_o.start_match = accept && (kind_i == KIND_MATCH);
  assign cmd_o.issue       = (state_q == S_SCAN);
  assign cmd_o.result      = (state_q == S_RESULT);
  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = (state_q == S_RESULT);

`ifndef NO_ASSERTIONS
  a_result_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT) |=> (state_q == S_IDLE))
    else $error("Result strobe lasted more than one cycle.");

  a_match_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == KIND_MATCH) |=> (state_q == S_SCAN))
    else $error("Accepted match item did not start a scan.");

  a_load_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == KIND_LOAD) |=> !busy_o)
    else $error("Load item left the controller busy.");
`endif

endmodule

### sv/greedy_nearest_timestamp_match.sv
`timescale 1ns / 1ps

// Greedy nearest-timestamp matcher.
// An item is accepted at a rising edge with start_i high and busy_o low.
// kind_i low loads stamp_i into the next free slot of the store in load
// order; loads beyond STORE_DEPTH entries are dropped. A load gives no
// result and leaves busy_o low.
// kind_i high matches stamp_i against every free stored entry. The block
// scans the loaded entries one per cycle through the stamp and free-mark
// memories and a single distance comparator. busy_o stays high from the
// accepting edge through the scan, the drain of the read and candidate
// registers, and the result state. In that last state done_o is high for
// one cycle with match_index_o, time_offset_o (stored minus trigger) and
// no_match_o. The chosen entry is then marked used. Ties resolve to the
// lowest index.
// The receiver cannot stall; each result must be taken in its cycle.
// Reset empties the store at once through the fill count; no clearing
// pass is needed, and the block accepts items in the first cycle after it.
module greedy_nearest_timestamp_match #(
  parameter int STORE_DEPTH = 1024,
  parameter int STAMP_BITS  = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic                                  kind_i,
  input  logic [STAMP_BITS-1:0]                 stamp_i,
  output logic                                  done_o,
  output logic [$clog2(STORE_DEPTH)-1:0]        match_index_o,
  output logic signed [STAMP_BITS:0]            time_offset_o,
  output logic                                  no_match_o
);
  import gntm_pkg::*;

  localparam int IdxW = $clog2(STORE_DEPTH);
  localparam int CntW = $clog2(STORE_DEPTH + 1);

  gntm_cmd_t    cmd;
  gntm_status_t status;

  gntm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  gntm_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .STAMP_BITS  (STAMP_BITS),
    .IDX_W       (IdxW),
    .CNT_W       (CntW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .stamp_i       (stamp_i),
    .match_index_o (match_index_o),
    .time_offset_o (time_offset_o),
    .no_match_o    (no_match_o)
  );

endmodule
